// ----- sv/rgbw_pixel_crossfade_engine_assert.svh -----
// Assertion macros for the crossfade engine checker.
// Both macros expect clk and rst_n in scope.
`ifndef RGBW_PIXEL_CROSSFADE_ENGINE_ASSERT_SVH
`define RGBW_PIXEL_CROSSFADE_ENGINE_ASSERT_SVH
// Same-cycle implication.
`define PXF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crossfade engine check failed");
// Next-cycle implication.
`define PXF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crossfade engine check failed");
`endif

// ----- sv/rgbw_pxf_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbw_pxf_pkg
// Shared types, opcodes and widths of the RGBW crossfade engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rgbw_pxf_pkg;

    localparam int PIXELS_DEF = 144;
    localparam int CHAN_W     = 8;
    localparam int DVD_W      = 24;
    localparam int DVS_W      = 16;
    localparam int DCNT_W     = 5;

    localparam logic [9:0] STEP_TIME_RST = 10'd10;

    localparam logic [1:0] OP_RANGE  = 2'd0;
    localparam logic [1:0] OP_SINGLE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  first_pixel;
        logic [9:0]  last_pixel;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  white;
        logic [15:0] duration_ms;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  read_red;
        logic [7:0]  read_green;
        logic [7:0]  read_blue;
        logic [7:0]  read_white;
        logic        frame_shown;
        logic        busy_res;
        logic [15:0] step_index;
    } res_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- sv/rgbw_pxf_div.sv -----
// ----------------------------------------------------------------------------
// rgbw_pxf_div
// Restoring divider, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rgbw_pxf_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rgbw_pxf_pkg::div_req_t req,
    output rgbw_pxf_pkg::div_rsp_t rsp
);
    import rgbw_pxf_pkg::*;

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W:0]    trial;
    logic              fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DVD_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = DCNT_W'(DVD_W - 1);
            rem_next = '0;
            quo_next = req.dividend;
            dvs_next = req.divisor;
        end
        else if (run_reg)
        begin
            // shift in one dividend bit, subtract where it fits
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- sv/rgbw_pxf_store.sv -----
// ----------------------------------------------------------------------------
// rgbw_pxf_store
// Pixel store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rgbw_pxf_store #(
    parameter int PIXELS = rgbw_pxf_pkg::PIXELS_DEF,
    parameter int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0] mem [PIXELS];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/rgbw_pixel_crossfade_engine.sv -----
// ----------------------------------------------------------------------------
// rgbw_pixel_crossfade_engine
// RGBW pixel store with range and single-pixel linear crossfades.
// ----------------------------------------------------------------------------
// One command beat is taken when start is high and busy is low; exactly one
// result beat follows, shown on result for one cycle with done high. The
// receiver cannot stall: capture the result in the cycle done is high. Items
// run one at a time. After reset the store is cleared, one pixel a cycle, while
// busy stays high. A read fetches one pixel; an idle tick only returns a result;
// a command first runs the steps division, then
// either writes its range (one pixel a cycle), fetches its source pixel, or
// sweeps the whole store for the average and scales the
// four channel sums by a reciprocal of PIXELS, one channel a cycle.
// A fade tick blends four channels through the shared divider and then writes
// its range. The serial divider is shared, and the store has a single write
// port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rgbw_pixel_crossfade_engine #(
    parameter int PIXELS = rgbw_pxf_pkg::PIXELS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rgbw_pxf_pkg::cmd_t cmd,
    output logic               done,
    output rgbw_pxf_pkg::res_t result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import rgbw_pxf_pkg::*;

    localparam int         AW    = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int         SW    = CHAN_W + $clog2(PIXELS + 1);
    localparam logic [10:0] PIX11 = 11'(PIXELS);

    // Average by reciprocal: floor(x / PIXELS) = (x * RM) >> RS for x < 2**SW.
    localparam int          RS      = SW + $clog2(PIXELS);
    localparam int          RW      = SW + 2;
    localparam logic [63:0] RM_FULL = ((64'd1 << RS) + 64'(PIXELS) - 64'd1) / 64'(PIXELS);
    localparam logic [RW-1:0] RM    = RW'(RM_FULL);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_NDIV = 4'd2;
    localparam logic [3:0] S_AVG  = 4'd3;
    localparam logic [3:0] S_ADIV = 4'd4;
    localparam logic [3:0] S_SRC  = 4'd5;
    localparam logic [3:0] S_BMUL = 4'd6;
    localparam logic [3:0] S_BSUM = 4'd7;
    localparam logic [3:0] S_BDIV = 4'd8;
    localparam logic [3:0] S_WR   = 4'd9;
    localparam logic [3:0] S_RD   = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [3:0]  state_reg, state_next;
    logic [9:0]  step_time_reg;
    cmd_t        cmd_reg, cmd_next;
    logic [15:0] total_reg, total_next;
    logic [15:0] cur_reg, cur_next;
    logic        fading_reg, fading_next;
    logic [31:0] from_reg, from_next;
    logic [31:0] to_reg, to_next;
    logic [9:0]  rf_reg, rf_next;
    logic [9:0]  rl_reg, rl_next;
    logic [10:0] cnt_reg, cnt_next;
    logic        rdv_reg, rdv_next;
    logic [SW-1:0] sum_reg [4];
    logic [SW-1:0] sum_next [4];
    logic [1:0]  ch_reg, ch_next;
    logic [31:0] color_reg, color_next;
    logic [10:0] wr_cnt_reg, wr_cnt_next;
    logic [9:0]  wr_hi_reg, wr_hi_next;
    logic [23:0] prod_a_reg, prod_a_next;
    logic [23:0] prod_b_reg, prod_b_next;
    logic [31:0] rd_reg, rd_next;
    logic        shown_reg, shown_next;
    logic [15:0] step_reg, step_next;
    logic        done_reg;
    res_t        result_reg;

    div_req_t    dreq;
    div_rsp_t    drsp;

    logic          st_we, st_re;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [31:0]   st_wdata, st_rdata;

    logic [9:0]  st_eff;
    logic [15:0] cur_inc;
    logic [9:0]  hi_sel;
    logic [1:0]  ch_inc;

    logic [SW+RW-1:0] avg_prod;
    logic [7:0]       avg_q;

    rgbw_pxf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    rgbw_pxf_store #(
        .PIXELS (PIXELS),
        .AW     (AW)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Configuration: step time, zero treated as one millisecond.
    assign pready = 1'b1;
    assign prdata = {22'd0, step_time_reg};
    assign st_eff = (step_time_reg == '0) ? 10'd1 : step_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg <= STEP_TIME_RST;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            step_time_reg <= pwdata[9:0];
        end
    end

    assign cur_inc = cur_reg + 16'd1;
    assign hi_sel  = (cmd_reg.op == OP_RANGE) ? cmd_reg.last_pixel : cmd_reg.first_pixel;
    assign ch_inc  = ch_reg + 2'd1;

    // Channel average: the quotient always fits in eight bits.
    assign avg_prod = (SW+RW)'(sum_reg[ch_reg]) * (SW+RW)'(RM);
    assign avg_q    = avg_prod[RS +: 8];

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        total_next  = total_reg;
        cur_next    = cur_reg;
        fading_next = fading_reg;
        from_next   = from_reg;
        to_next     = to_reg;
        rf_next     = rf_reg;
        rl_next     = rl_reg;
        cnt_next    = cnt_reg;
        rdv_next    = 1'b0;
        sum_next    = sum_reg;
        ch_next     = ch_reg;
        color_next  = color_reg;
        wr_cnt_next = wr_cnt_reg;
        wr_hi_next  = wr_hi_reg;
        prod_a_next = prod_a_reg;
        prod_b_next = prod_b_reg;
        rd_next     = rd_reg;
        shown_next  = shown_reg;
        step_next   = step_reg;
        dreq        = '0;
        st_we       = 1'b0;
        st_waddr    = wr_cnt_reg[AW-1:0];
        st_wdata    = color_reg;
        st_re       = 1'b0;
        st_raddr    = cmd_reg.first_pixel[AW-1:0];

        case (state_reg)
            S_CLR:
            begin
                // sweep zeros through the store after reset
                st_we    = 1'b1;
                st_waddr = cnt_reg[AW-1:0];
                st_wdata = '0;
                cnt_next = cnt_reg + 11'd1;
                if (cnt_reg == PIX11 - 11'd1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    rd_next    = '0;
                    shown_next = 1'b0;
                    step_next  = '0;
                    case (cmd.op)
                        OP_RANGE, OP_SINGLE:
                        begin
                            // abort any running fade, find the step count
                            fading_next = 1'b0;
                            cur_next    = '0;
                            dreq.start    = 1'b1;
                            dreq.dividend = DVD_W'(cmd.duration_ms);
                            dreq.divisor  = DVS_W'(st_eff);
                            state_next    = S_NDIV;
                        end
                        OP_TICK:
                        begin
                            if (fading_reg)
                            begin
                                cur_next    = cur_inc;
                                shown_next  = 1'b1;
                                step_next   = cur_inc;
                                fading_next = !(cur_inc >= total_reg);
                                ch_next     = '0;
                                state_next  = S_BMUL;
                            end
                            else
                            begin
                                state_next = S_FIN;
                            end
                        end
                        default:
                        begin
                            st_re      = 1'b1;
                            st_raddr   = cmd.first_pixel[AW-1:0];
                            state_next = S_RD;
                        end
                    endcase
                end
            end
            S_NDIV:
            begin
                if (drsp.done)
                begin
                    if (drsp.quotient[15:0] == '0)
                    begin
                        color_next  = {cmd_reg.white, cmd_reg.blue, cmd_reg.green,
                                       cmd_reg.red};
                        wr_cnt_next = {1'b0, cmd_reg.first_pixel};
                        wr_hi_next  = hi_sel;
                        shown_next  = 1'b1;
                        state_next  = S_WR;
                    end
                    else
                    begin
                        total_next = drsp.quotient[15:0];
                        to_next    = {cmd_reg.white, cmd_reg.blue, cmd_reg.green,
                                      cmd_reg.red};
                        rf_next    = cmd_reg.first_pixel;
                        rl_next    = hi_sel;
                        if (cmd_reg.op == OP_RANGE)
                        begin
                            cnt_next   = '0;
                            sum_next   = '{default: '0};
                            state_next = S_AVG;
                        end
                        else
                        begin
                            st_re      = 1'b1;
                            state_next = S_SRC;
                        end
                    end
                end
            end
            S_AVG:
            begin
                // issue one read a cycle, accumulate the beat in the next cycle
                if (cnt_reg < PIX11)
                begin
                    st_re    = 1'b1;
                    st_raddr = cnt_reg[AW-1:0];
                    cnt_next = cnt_reg + 11'd1;
                    rdv_next = 1'b1;
                end
                if (rdv_reg)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        sum_next[k] = sum_reg[k] + SW'(st_rdata[8*k +: 8]);
                    end
                end
                if (!(cnt_reg < PIX11) && !rdv_reg)
                begin
                    ch_next    = '0;
                    state_next = S_ADIV;
                end
            end
            S_ADIV:
            begin
                // one channel a cycle: sum times the reciprocal of PIXELS
                from_next[8*ch_reg +: 8] = avg_q;
                if (ch_reg == 2'd3)
                begin
                    fading_next = 1'b1;
                    state_next  = S_FIN;
                end
                else
                begin
                    ch_next = ch_inc;
                end
            end
            S_SRC:
            begin
                // source pixel beyond the store fades from black
                from_next   = ({1'b0, cmd_reg.first_pixel} < PIX11) ? st_rdata : '0;
                fading_next = 1'b1;
                state_next  = S_FIN;
            end
            S_BMUL:
            begin
                prod_a_next = 24'(from_reg[8*ch_reg +: 8]) * 24'(total_reg - cur_reg);
                prod_b_next = 24'(to_reg[8*ch_reg +: 8]) * 24'(cur_reg);
                state_next  = S_BSUM;
            end
            S_BSUM:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = prod_a_reg + prod_b_reg;
                dreq.divisor  = total_reg;
                state_next    = S_BDIV;
            end
            S_BDIV:
            begin
                if (drsp.done)
                begin
                    color_next[8*ch_reg +: 8] = drsp.quotient[7:0];
                    if (ch_reg == 2'd3)
                    begin
                        wr_cnt_next = {1'b0, rf_reg};
                        wr_hi_next  = rl_reg;
                        state_next  = S_WR;
                    end
                    else
                    begin
                        ch_next    = ch_inc;
                        state_next = S_BMUL;
                    end
                end
            end
            S_WR:
            begin
                // drop pixels beyond the store, stop at the range end
                if ((wr_cnt_reg <= {1'b0, wr_hi_reg}) && (wr_cnt_reg < PIX11))
                begin
                    st_we       = 1'b1;
                    wr_cnt_next = wr_cnt_reg + 11'd1;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_RD:
            begin
                rd_next    = ({1'b0, cmd_reg.first_pixel} < PIX11) ? st_rdata : '0;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLR;
            cnt_reg    <= '0;
            fading_reg <= 1'b0;
            cur_reg    <= '0;
            total_reg  <= '0;
            rdv_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            fading_reg <= fading_next;
            cur_reg    <= cur_next;
            total_reg  <= total_next;
            rdv_reg    <= rdv_next;
            done_reg   <= (state_reg == S_FIN);
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        from_reg   <= from_next;
        to_reg     <= to_next;
        rf_reg     <= rf_next;
        rl_reg     <= rl_next;
        sum_reg    <= sum_next;
        ch_reg     <= ch_next;
        color_reg  <= color_next;
        wr_cnt_reg <= wr_cnt_next;
        wr_hi_reg  <= wr_hi_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        rd_reg     <= rd_next;
        shown_reg  <= shown_next;
        step_reg   <= step_next;
        if (state_reg == S_FIN)
        begin
            result_reg.read_red    <= rd_reg[7:0];
            result_reg.read_green  <= rd_reg[15:8];
            result_reg.read_blue   <= rd_reg[23:16];
            result_reg.read_white  <= rd_reg[31:24];
            result_reg.frame_shown <= shown_reg;
            result_reg.busy_res    <= fading_reg;
            result_reg.step_index  <= step_reg;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- sv/rgbw_pxf_checker.sv -----
// ----------------------------------------------------------------------------
// rgbw_pxf_checker
// Port-level checks of the crossfade engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rgbw_pixel_crossfade_engine_assert.svh"
module rgbw_pxf_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input rgbw_pxf_pkg::res_t result,
    input logic               pready
);
    import rgbw_pxf_pkg::*;

    `PXF_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `PXF_ASSERT_NEXT(a_done_single, done, !done)
    `PXF_ASSERT_NOW(a_step_frame, done && (result.step_index != 16'd0), result.frame_shown)
    `PXF_ASSERT_NOW(a_read_noframe, done && result.frame_shown, (result.read_red == 8'd0) && (result.read_white == 8'd0))
    `PXF_ASSERT_NOW(a_pready, 1'b1, pready)

endmodule

bind rgbw_pixel_crossfade_engine rgbw_pxf_checker u_pxf_checker (.*);
